// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the exclusive-time block.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons)
`define ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

// ===== rtl/cset_pkg.sv =====
// Types and codes of the call-stack exclusive-time block.
// No dependencies; used by the interfaces, the adder and the top level.
package cset_pkg;

  localparam int ID_W   = 6;
  localparam int TIME_W = 32;
  localparam int ACC_W  = 48;
  localparam int NUM_IDS = 1 << ID_W;

  typedef logic [1:0]               req_type_t;
  typedef logic [1:0]               status_t;
  typedef logic [ID_W-1:0]          id_t;
  typedef logic [TIME_W-1:0]        time_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef logic [1:0]               alu_op_t;

  // request types (type three acts as a read)
  localparam req_type_t REQ_START = 2'd0;
  localparam req_type_t REQ_END   = 2'd1;
  localparam req_type_t REQ_READ  = 2'd2;

  // result status
  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_MISMATCH = 2'd1;
  localparam status_t STATUS_EMPTY    = 2'd2;
  localparam status_t STATUS_FULL     = 2'd3;

  // shared adder operations
  localparam alu_op_t ALU_DUR = 2'd0;  // end - start (duration minus one)
  localparam alu_op_t ALU_ADD = 2'd1;  // acc + dur + 1
  localparam alu_op_t ALU_SUB = 2'd2;  // acc - (dur + 1)

endpackage

// ===== rtl/cset_req_if.sv =====
// Request channel: valid/ready handshake carrying one event or read.
// Depends on cset_pkg.
interface cset_req_if;
  logic              valid;
  logic              ready;
  cset_pkg::req_type_t req_type;
  cset_pkg::id_t     func_id;
  cset_pkg::time_t   event_time;

  modport source (output valid, req_type, func_id, event_time, input ready);
  modport sink   (input valid, req_type, func_id, event_time, output ready);
endinterface

// ===== rtl/cset_rsp_if.sv =====
// Response channel: valid/ready handshake carrying status and one accumulator.
// Depends on cset_pkg.
interface cset_rsp_if;
  logic             valid;
  logic             ready;
  cset_pkg::status_t status;
  cset_pkg::id_t    result_id;
  cset_pkg::acc_t   excl_time;

  modport source (output valid, status, result_id, excl_time, input ready);
  modport sink   (input valid, status, result_id, excl_time, output ready);
endinterface

// ===== rtl/cset_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cset_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/cset_alu.sv =====
// Shared 48-bit adder: forms durations and updates accumulators.
// Depends on cset_pkg.
module cset_alu (
  input  cset_pkg::alu_op_t op,
  input  cset_pkg::acc_t    acc,
  input  cset_pkg::acc_t    dur,
  input  cset_pkg::time_t   t_end,
  input  cset_pkg::time_t   t_start,
  output cset_pkg::acc_t    sum
);

  localparam int PAD_W = cset_pkg::ACC_W - cset_pkg::TIME_W;

  logic [cset_pkg::ACC_W-1:0] opa;
  logic [cset_pkg::ACC_W-1:0] opb;
  logic                       cin;

  // operand select; subtraction as a + ~b + 1
  always_comb begin
    unique case (op)
      cset_pkg::ALU_DUR: begin
        opa = {{PAD_W{1'b0}}, t_end};
        opb = ~{{PAD_W{1'b0}}, t_start};
        cin = 1'b1;
      end
      cset_pkg::ALU_SUB: begin
        // ~dur equals -(dur + 1)
        opa = acc;
        opb = ~dur;
        cin = 1'b0;
      end
      default: begin
        opa = acc;
        opb = dur;
        cin = 1'b1;
      end
    endcase
  end

  assign sum = opa + opb + {{(cset_pkg::ACC_W-1){1'b0}}, cin};

endmodule

// ===== rtl/call_stack_exclusive_time_core.sv =====
// Top level of the call-stack exclusive-time profiler.
// Depends on cset_pkg, cset_req_if, cset_rsp_if, cset_ram, cset_alu, assert_macros.svh.
//
// Usage:
//   req channel: req_type (start, end, read), func_id, event_time.
//   rsp channel: status, result_id and the accumulator of func_id after the item.
//   A start pushes (id, time); an end pops the top entry, adds end - start + 1
//   to that function and subtracts it from the caller left on top.
//   Every transaction on req yields exactly one transaction on rsp.
// Sequencing:
//   One item at a time; req.ready is high only while the sequencer is idle.
//   Start, read, empty/full errors: decode, accumulator read, result. End
//   with id mismatch adds a stack read first; a good end then updates its own
//   accumulator, and the caller's if any, in series: one accumulator RAM and
//   one shared 48-bit adder, each end doing up to two read-modify-writes.
// Reset:
//   rst (synchronous, active high) empties the stack and zeroes every
//   accumulator at once through per-entry valid bits; no clearing pass.
// Stall:
//   A result waits in the output register while rsp.ready is low; the next
//   item is still accepted and finishes up to its result, then waits.
`include "assert_macros.svh"
module call_stack_exclusive_time_core #(
  parameter int NUM_FUNCS   = 64,
  parameter int STACK_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  cset_req_if.sink   req,
  cset_rsp_if.source rsp
);

  // reachable accumulators: func_id is six bits wide
  localparam int ACC_D  = (NUM_FUNCS < cset_pkg::NUM_IDS) ? NUM_FUNCS : cset_pkg::NUM_IDS;
  localparam int AAW    = (ACC_D > 1) ? $clog2(ACC_D) : 1;
  localparam int SAW    = $clog2(STACK_DEPTH);
  localparam int CW     = $clog2(STACK_DEPTH + 1);
  localparam int STK_W  = cset_pkg::ID_W + cset_pkg::TIME_W;

  // sequencer states
  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_DECODE     = 3'd1;
  localparam logic [2:0] S_TOP_WAIT   = 3'd2;
  localparam logic [2:0] S_ADD_SELF   = 3'd3;
  localparam logic [2:0] S_CALLER_RD  = 3'd4;
  localparam logic [2:0] S_SUB_CALLER = 3'd5;
  localparam logic [2:0] S_RD_ACC     = 3'd6;
  localparam logic [2:0] S_RESULT     = 3'd7;

  logic [2:0]                  state, state_next;
  cset_pkg::req_type_t         kind;
  cset_pkg::id_t               id;
  cset_pkg::time_t             tstamp;
  cset_pkg::status_t           status, status_next;
  cset_pkg::acc_t              dur;
  cset_pkg::id_t               caller_id;
  logic                        has_caller;
  logic [CW-1:0]               count, count_next;
  logic [cset_pkg::NUM_IDS-1:0] acc_valid;

  logic                        out_valid;
  cset_pkg::status_t           out_status;
  cset_pkg::id_t               out_id;
  cset_pkg::acc_t              out_excl;

  logic [CW-1:0]               top_idx;
  logic [CW-1:0]               caller_idx;
  logic                        stk_full;
  logic                        stk_empty;
  logic                        pop_ok;
  logic                        out_load;

  logic                        stk_we;
  logic [STK_W-1:0]            stk_wdata;
  logic                        stk_re;
  logic [SAW-1:0]              stk_raddr;
  logic [STK_W-1:0]            stk_rdata;
  cset_pkg::id_t               top_id;
  cset_pkg::time_t             top_time;

  logic                        acc_we;
  cset_pkg::id_t               acc_wid;
  logic                        acc_re;
  cset_pkg::id_t               acc_rid;
  cset_pkg::id_t               acc_vid;
  logic [cset_pkg::ACC_W-1:0]  acc_rdata;
  cset_pkg::acc_t              acc_val;

  cset_pkg::alu_op_t           alu_op;
  cset_pkg::acc_t              alu_sum;

  // stack bookkeeping
  assign top_idx    = count - CW'(1);
  assign caller_idx = count - CW'(2);
  assign stk_full   = (count >= CW'(STACK_DEPTH));
  assign stk_empty  = (count == '0);
  assign top_id     = stk_rdata[STK_W-1:cset_pkg::TIME_W];
  assign top_time   = stk_rdata[cset_pkg::TIME_W-1:0];
  assign pop_ok     = (top_id == id);
  assign stk_wdata  = {id, tstamp};
  assign out_load   = (state == S_RESULT) && (!out_valid || rsp.ready);

  // an accumulator never written (or out of range) reads as zero
  assign acc_vid = (state == S_SUB_CALLER) ? caller_id : id;
  assign acc_val = acc_valid[acc_vid] ? cset_pkg::acc_t'(acc_rdata) : '0;

  // sequencer
  always_comb begin
    state_next  = state;
    status_next = status;
    count_next  = count;
    stk_we      = 1'b0;
    stk_re      = 1'b0;
    stk_raddr   = top_idx[SAW-1:0];
    acc_we      = 1'b0;
    acc_wid     = id;
    acc_re      = 1'b0;
    acc_rid     = id;
    alu_op      = cset_pkg::ALU_DUR;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next  = S_DECODE;
          status_next = cset_pkg::STATUS_OK;
        end
      end
      S_DECODE: begin
        state_next = S_RD_ACC;
        case (kind)
          cset_pkg::REQ_START: begin
            if (stk_full) begin
              status_next = cset_pkg::STATUS_FULL;
            end else begin
              stk_we     = 1'b1;
              count_next = count + CW'(1);
            end
          end
          cset_pkg::REQ_END: begin
            if (stk_empty) begin
              status_next = cset_pkg::STATUS_EMPTY;
            end else begin
              stk_re     = 1'b1;
              state_next = S_TOP_WAIT;
            end
          end
          default: begin
          end
        endcase
      end
      S_TOP_WAIT: begin
        if (!pop_ok) begin
          status_next = cset_pkg::STATUS_MISMATCH;
          state_next  = S_RD_ACC;
        end else begin
          count_next = top_idx;
          acc_re     = 1'b1;
          stk_re     = (count >= CW'(2));
          stk_raddr  = caller_idx[SAW-1:0];
          state_next = S_ADD_SELF;
        end
      end
      S_ADD_SELF: begin
        alu_op     = cset_pkg::ALU_ADD;
        acc_we     = (32'(id) < 32'(NUM_FUNCS));
        state_next = has_caller ? S_CALLER_RD : S_RD_ACC;
      end
      S_CALLER_RD: begin
        acc_re     = 1'b1;
        acc_rid    = caller_id;
        state_next = S_SUB_CALLER;
      end
      S_SUB_CALLER: begin
        alu_op     = cset_pkg::ALU_SUB;
        acc_wid    = caller_id;
        acc_we     = (32'(caller_id) < 32'(NUM_FUNCS));
        state_next = S_RD_ACC;
      end
      S_RD_ACC: begin
        acc_re     = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      acc_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (acc_we) begin
        acc_valid[acc_wid] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    status <= status_next;
    if (state == S_IDLE && req.valid) begin
      kind   <= req.req_type;
      id     <= req.func_id;
      tstamp <= req.event_time;
    end
    if (state == S_TOP_WAIT) begin
      dur        <= alu_sum;
      has_caller <= (count >= CW'(2));
    end
    if (state == S_ADD_SELF) begin
      caller_id <= top_id;
    end
    if (out_load) begin
      out_status <= status;
      out_id     <= id;
      out_excl   <= acc_val;
    end
  end

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.result_id = out_id;
  assign rsp.excl_time = out_excl;

  // call stack: {id, start time} per entry
  cset_ram #(
    .WIDTH (STK_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (count[SAW-1:0]),
    .wdata (stk_wdata),
    .re    (stk_re),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // per-function accumulators
  cset_ram #(
    .WIDTH (cset_pkg::ACC_W),
    .DEPTH (ACC_D)
  ) u_acc (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_wid[AAW-1:0]),
    .wdata (alu_sum),
    .re    (acc_re),
    .raddr (acc_rid[AAW-1:0]),
    .rdata (acc_rdata)
  );

  cset_alu u_alu (
    .op      (alu_op),
    .acc     (acc_val),
    .dur     (dur),
    .t_end   (tstamp),
    .t_start (top_time),
    .sum     (alu_sum)
  );

  // checks
  `ASSERT_IMPLY(a_count_bound, clk, rst, 1'b1, count <= CW'(STACK_DEPTH))
  `ASSERT_IMPLY(a_push_room, clk, rst, stk_we, count < CW'(STACK_DEPTH))
  `ASSERT_NEXT(a_pop_one, clk, rst, state == S_TOP_WAIT && pop_ok, count == $past(count) - CW'(1))
  `ASSERT_NEXT(a_result_once, clk, rst, rsp.valid && rsp.ready && state != S_RESULT, !rsp.valid)

endmodule
